### hdl/ewah_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types, constants and tuning/sine tables for the envelope/LFO wah.
// No dependencies; used by the top level.
package ewah_pkg;

    localparam int SAMPLE_RATE = 48000;
    localparam int SAMPLE_BITS = 24;
    localparam int CURVE_DEPTH = 256;
    localparam int IDX_W       = $clog2(CURVE_DEPTH);

    localparam longint unsigned ONE_Q30     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned PI_Q30      = 64'd3373259426;
    localparam longint unsigned LN2_Q30     = 64'd744261118;
    localparam longint unsigned K_Q24_L     = 64'd4660338;

    localparam logic [24:0] ONE_Q24      = 25'd16777216;
    localparam logic [23:0] POS_BASE     = 24'd2013266;
    localparam logic [23:0] POS_LFO      = 24'd9227469;
    localparam logic [23:0] POS_ENV_AUTO = 24'd5872026;
    localparam logic [23:0] POS_PEDAL    = 24'd11744051;
    localparam logic [23:0] POS_ENV_MAN  = 24'd6710886;
    localparam logic [23:0] OUT_WET      = 24'd7381975;
    localparam logic [23:0] OUT_DRY      = 24'd2348810;

    typedef enum logic [2:0] {
        REG_AUTO_MODE    = 3'd0,
        REG_PEDAL        = 3'd1,
        REG_SENSITIVITY  = 3'd2,
        REG_LFO_STEP     = 3'd3,
        REG_ATTACK       = 3'd4,
        REG_RELEASE      = 3'd5
    } ewah_reg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ENV_MUL0,
        ST_ENV_MUL1,
        ST_ENV_SUM,
        ST_SENS_MUL,
        ST_SENS_TAKE,
        ST_POS_MUL,
        ST_POS_SUM,
        ST_IDX,
        ST_TAB,
        ST_A2_MUL,
        ST_A2_TAKE,
        ST_GA2_MUL,
        ST_V1_MUL0,
        ST_V1_MUL1,
        ST_V2_MUL0,
        ST_V2_MUL1,
        ST_OUT_MUL0,
        ST_OUT_MUL1,
        ST_OUT_SUM
    } ewah_state_t;

    typedef logic [CURVE_DEPTH-1:0][24:0] curve_tab_t;

    // unsigned quotient by shift and subtract, table build only
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        longint unsigned m;
        q = 0;
        r = 0;
        m = num;
        for (int k = 0; k < 64; k++) begin
            r = (r << 1) | (m >> 63);
            m = m << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    // sin(x), x in [0, pi/2], Q30 Taylor series with truncated terms
    function automatic longint unsigned sin_q30(input longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (longint unsigned n = 1; n <= 7; n++) begin
            term = udiv64((term * x2) >> 30, (2 * n) * (2 * n + 1));
            if (n[0]) sum = sum - term;
            else      sum = sum + term;
        end
        return sum;
    endfunction

    // e^y, y in [0, 1), Q30
    function automatic longint unsigned exp_q30(input longint unsigned y);
        longint unsigned term;
        longint unsigned sum;
        term = ONE_Q30;
        sum  = ONE_Q30;
        for (longint unsigned n = 1; n <= 12; n++) begin
            term = udiv64((term * y) >> 30, n);
            sum  = sum + term;
        end
        return sum;
    endfunction

    // Exponential 100..1600 Hz tuning: g = tan(w) or normalizer 1/(1 + g(g+k))
    function automatic curve_tab_t build_tune(input logic want_norm);
        curve_tab_t      t;
        longint unsigned n;
        longint unsigned r;
        longint unsigned f;
        longint unsigned ey;
        longint unsigned hz;
        longint unsigned w;
        longint unsigned s;
        longint unsigned c;
        longint unsigned g;
        longint unsigned gg;
        longint unsigned d1;
        d1 = longint'(CURVE_DEPTH - 1);
        for (longint unsigned i = 0; i < CURVE_DEPTH; i++) begin
            n  = udiv64(4 * i, d1);
            r  = (4 * i) - n * d1;
            f  = udiv64(r << 30, d1);
            ey = exp_q30((f * LN2_Q30) >> 30);
            hz = ey * (64'd100 << n);
            w  = (udiv64(hz, SAMPLE_RATE) * PI_Q30) >> 30;
            if (w > HALF_PI_Q30) w = HALF_PI_Q30;
            s = sin_q30(w);
            c = sin_q30(HALF_PI_Q30 - w);
            if (c == 0) c = 1;
            g = udiv64(s << 24, c);
            if (g > 64'd16777215) g = 64'd16777215;
            gg = (g * (g + K_Q24_L)) >> 24;
            if (want_norm) t[i] = 25'(udiv64(64'd1 << 48, 64'd16777216 + gg));
            else           t[i] = 25'(g);
        end
        return t;
    endfunction

    // Sine LFO shape, 0..1 in Q24 (offset sine)
    function automatic curve_tab_t build_sine();
        curve_tab_t      t;
        longint unsigned q;
        longint unsigned r;
        longint unsigned x;
        longint unsigned s;
        longint unsigned v;
        for (longint unsigned i = 0; i < CURVE_DEPTH; i++) begin
            q = (4 * i) / CURVE_DEPTH;
            r = (4 * i) % CURVE_DEPTH;
            x = (HALF_PI_Q30 * r) / CURVE_DEPTH;
            s = q[0] ? sin_q30(HALF_PI_Q30 - x) : sin_q30(x);
            v = q[1] ? ONE_Q30 - s : ONE_Q30 + s;
            t[i] = 25'(v >> 7);
        end
        return t;
    endfunction

    localparam curve_tab_t TUNE_G    = build_tune(1'b0);
    localparam curve_tab_t TUNE_NORM = build_tune(1'b1);
    localparam curve_tab_t SINE01    = build_sine();

endpackage
`default_nettype wire

### hdl/envelope_lfo_swept_wah_filter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Auto-wah: envelope follower + sine LFO or pedal sweep driving a state-variable band-pass.
// Depends on ewah_pkg (tables, constants, state type).
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------
//   in      | to block  | in_valid/in_stall  | sample_in  (s24, Q1.23)
//   out     | from blk  | out_valid/out_stall| sample_out (s24, Q1.23, sat)
//   cfg     | to block  | cfg_wr_en          | cfg_index, cfg_data
//
// An item is accepted in ST_IDLE, then runs through 19 sequencer steps; the 13 products
// among them all go through a single registered 26x36 signed multiplier.
// in_stall is high from acceptance until the result is written to the output
// register; a new item can be taken while that result still waits.
// If the output register is still full and stalled at the final step, the sequencer holds.
// rst_n clears the sequencer, the output valid flag and the filter/envelope/LFO state, and loads the config defaults.
module envelope_lfo_swept_wah_filter_top (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic signed [ewah_pkg::SAMPLE_BITS-1:0] sample_in,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [ewah_pkg::SAMPLE_BITS-1:0]    sample_out,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [2:0]                            cfg_index,
    input  wire logic [31:0]                           cfg_data
);
    import ewah_pkg::*;

    ewah_state_t state_reg, state_next;

    // configuration
    logic        auto_mode_reg;
    logic [15:0] pedal_reg;
    logic [15:0] sens_reg;
    logic [31:0] step_reg;
    logic [23:0] attack_reg;
    logic [23:0] release_reg;

    // persistent state
    logic [23:0]        env_reg;
    logic [31:0]        phase_reg;
    logic signed [31:0] bp_reg;
    logic signed [31:0] lp_reg;

    // per-item working registers
    logic signed [23:0] x_reg;
    logic [23:0]        a_reg;
    logic [23:0]        cf_reg;
    logic signed [61:0] prod_reg;
    logic signed [61:0] acc_reg;
    logic [24:0]        t_reg;
    logic [24:0]        pos_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [23:0]        g_reg;
    logic [24:0]        a1_reg;
    logic [23:0]        a2_reg;
    logic [23:0]        ga2_reg;
    logic signed [32:0] v3_reg;
    logic signed [35:0] v1_reg;
    logic signed [35:0] v2s_reg;
    logic signed [23:0] out_reg;
    logic               out_valid_reg;

    // shared multiplier operands
    logic signed [25:0] mul_a;
    logic signed [35:0] mul_b;
    logic signed [61:0] prod_next;

    logic               in_acc;
    logic               out_acc;
    logic               out_room;
    logic signed [23:0] x_in;
    logic [23:0]        a_in;
    logic signed [62:0] mac_sum;
    logic [25:0]        e3;
    logic [24:0]        e24;
    logic [26:0]        pos_sum;
    logic [33:0]        idx_sum;
    logic signed [37:0] bp_upd;
    logic signed [37:0] lp_upd;
    logic signed [38:0] y_w;

    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        if (v > 38'sd2147483647)       return 32'sh7fffffff;
        else if (v < -38'sd2147483648) return 32'sh80000000;
        else                           return v[31:0];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [38:0] v);
        if (v > 39'sd8388607)       return 24'sh7fffff;
        else if (v < -39'sd8388608) return 24'sh800000;
        else                        return v[23:0];
    endfunction

    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = out_valid_reg && !out_stall;
    assign out_room = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign sample_out = out_reg;

    assign x_in = sample_in;
    assign a_in = x_in[23] ? 24'(~x_in + 24'sd1) : 24'(x_in);

    assign prod_next = 62'(mul_a * mul_b);
    assign mac_sum   = 63'(acc_reg) + 63'(prod_reg);

    // envelope * 3, clamped at full scale, then scaled to Q24
    assign e3  = {2'b00, env_reg} + {1'b0, env_reg, 1'b0};
    assign e24 = (e3 > 26'd8388608) ? 25'd16777216 : {e3[23:0], 1'b0};

    assign pos_sum = (auto_mode_reg ? {3'b000, POS_BASE} : 27'd0)
                   + {2'b00, acc_reg[48:24]} + {2'b00, prod_reg[48:24]};
    // round(pos * (depth-1)) in Q24
    assign idx_sum = {1'b0, pos_reg, 8'b0} - {9'b0, pos_reg} + 34'd8388608;

    assign bp_upd = (38'(v1_reg) <<< 1) - 38'(bp_reg);
    assign lp_upd = 38'(lp_reg) + (38'(v2s_reg) <<< 1);
    assign y_w    = 39'(mac_sum >>> 24);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (in_acc) state_next = ST_ENV_MUL0;
            ST_ENV_MUL0:  state_next = ST_ENV_MUL1;
            ST_ENV_MUL1:  state_next = ST_ENV_SUM;
            ST_ENV_SUM:   state_next = ST_SENS_MUL;
            ST_SENS_MUL:  state_next = ST_SENS_TAKE;
            ST_SENS_TAKE: state_next = ST_POS_MUL;
            ST_POS_MUL:   state_next = ST_POS_SUM;
            ST_POS_SUM:   state_next = ST_IDX;
            ST_IDX:       state_next = ST_TAB;
            ST_TAB:       state_next = ST_A2_MUL;
            ST_A2_MUL:    state_next = ST_A2_TAKE;
            ST_A2_TAKE:   state_next = ST_GA2_MUL;
            ST_GA2_MUL:   state_next = ST_V1_MUL0;
            ST_V1_MUL0:   state_next = ST_V1_MUL1;
            ST_V1_MUL1:   state_next = ST_V2_MUL0;
            ST_V2_MUL0:   state_next = ST_V2_MUL1;
            ST_V2_MUL1:   state_next = ST_OUT_MUL0;
            ST_OUT_MUL0:  state_next = ST_OUT_MUL1;
            ST_OUT_MUL1:  state_next = ST_OUT_SUM;
            ST_OUT_SUM:   if (out_room) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // multiplier operand select per step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_ENV_MUL0:
            begin
                mul_a = {2'b00, cf_reg};
                mul_b = {12'b0, env_reg};
            end
            ST_ENV_MUL1:
            begin
                mul_a = {1'b0, ONE_Q24 - {1'b0, cf_reg}};
                mul_b = {12'b0, a_reg};
            end
            ST_ENV_SUM:
            begin
                if (auto_mode_reg)
                begin
                    mul_a = {2'b00, POS_LFO};
                    mul_b = {11'b0, SINE01[phase_reg[31:32-IDX_W]]};
                end
                else
                begin
                    mul_a = {2'b00, POS_PEDAL};
                    mul_b = {12'b0, pedal_reg, 8'b0};
                end
            end
            ST_SENS_MUL:
            begin
                mul_a = {10'b0, sens_reg};
                mul_b = {11'b0, e24};
            end
            ST_POS_MUL:
            begin
                mul_a = {2'b00, auto_mode_reg ? POS_ENV_AUTO : POS_ENV_MAN};
                mul_b = {11'b0, t_reg};
            end
            ST_A2_MUL:
            begin
                mul_a = {2'b00, g_reg};
                mul_b = {11'b0, a1_reg};
            end
            ST_GA2_MUL:
            begin
                mul_a = {2'b00, g_reg};
                mul_b = {12'b0, a2_reg};
            end
            ST_V1_MUL0:
            begin
                mul_a = {1'b0, a1_reg};
                mul_b = 36'(bp_reg);
            end
            ST_V1_MUL1:
            begin
                mul_a = {2'b00, a2_reg};
                mul_b = 36'(v3_reg);
            end
            ST_V2_MUL0:
            begin
                mul_a = {2'b00, a2_reg};
                mul_b = 36'(bp_reg);
            end
            ST_V2_MUL1:
            begin
                mul_a = {2'b00, ga2_reg};
                mul_b = 36'(v3_reg);
            end
            ST_OUT_MUL0:
            begin
                mul_a = {2'b00, OUT_WET};
                mul_b = v1_reg;
            end
            // dry product stays in prod_reg while the final step holds
            ST_OUT_MUL1,
            ST_OUT_SUM:
            begin
                mul_a = {2'b00, OUT_DRY};
                mul_b = 36'(x_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // control, configuration and persistent state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            auto_mode_reg <= 1'b1;
            pedal_reg     <= 16'd16384;
            sens_reg      <= 16'd39322;
            step_reg      <= 32'd683565;
            attack_reg    <= 24'd16719066;
            release_reg   <= 24'd16774720;
            env_reg       <= '0;
            phase_reg     <= '0;
            bp_reg        <= '0;
            lp_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_AUTO_MODE:   auto_mode_reg <= cfg_data[0];
                    REG_PEDAL:       pedal_reg     <= cfg_data[15:0];
                    REG_SENSITIVITY: sens_reg      <= cfg_data[15:0];
                    REG_LFO_STEP:    step_reg      <= cfg_data;
                    REG_ATTACK:      attack_reg    <= cfg_data[23:0];
                    REG_RELEASE:     release_reg   <= cfg_data[23:0];
                    default:         ;
                endcase
            end

            // LFO advances before use, only in auto mode
            if (in_acc && auto_mode_reg)
                phase_reg <= phase_reg + step_reg;

            if (state_reg == ST_ENV_SUM)
                env_reg <= mac_sum[47:24];
            if (state_reg == ST_OUT_MUL0)
                bp_reg <= sat32(bp_upd);
            if (state_reg == ST_OUT_MUL1)
                lp_reg <= sat32(lp_upd);

            if (state_reg == ST_OUT_SUM && out_room)
                out_valid_reg <= 1'b1;
            else if (out_acc)
                out_valid_reg <= 1'b0;
        end
    end

    // working registers (no reset needed)
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (in_acc)
        begin
            x_reg  <= x_in;
            a_reg  <= a_in;
            cf_reg <= (a_in > env_reg) ? attack_reg : release_reg;
            v3_reg <= 33'(x_in) - 33'(lp_reg);
        end
        case (state_reg)
            ST_ENV_MUL1,
            ST_SENS_MUL,
            ST_V1_MUL1,
            ST_V2_MUL1,
            ST_OUT_MUL1:  acc_reg <= prod_reg;
            ST_SENS_TAKE: t_reg   <= prod_reg[40:16];
            ST_POS_SUM:   pos_reg <= (pos_sum > 27'(ONE_Q24)) ? ONE_Q24 : pos_sum[24:0];
            ST_IDX:       idx_reg <= idx_sum[31:24];
            ST_TAB:
            begin
                g_reg  <= TUNE_G[idx_reg][23:0];
                a1_reg <= TUNE_NORM[idx_reg];
            end
            ST_A2_TAKE:   a2_reg  <= prod_reg[47:24];
            ST_V1_MUL0:   ga2_reg <= prod_reg[47:24];
            ST_V2_MUL0:   v1_reg  <= 36'(mac_sum >>> 24);
            ST_OUT_MUL0:  v2s_reg <= 36'(mac_sum >>> 24);
            ST_OUT_SUM:   if (out_room) out_reg <= sat24(y_w);
            default:      ;
        endcase
    end

endmodule
`default_nettype wire

### hdl/ewah_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks for the wah top level, bound to it below.
// Depends on ewah_pkg for the sample width.
module ewah_port_assert (
    input wire logic                                   clk,
    input wire logic                                   rst_n,
    input wire logic                                   in_valid,
    input wire logic                                   in_stall,
    input wire logic                                   out_valid,
    input wire logic                                   out_stall,
    input wire logic signed [ewah_pkg::SAMPLE_BITS-1:0] sample_out
);
    import ewah_pkg::*;

    // an accepted item keeps the block busy for the next cycles
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken again right after an item");

    a_busy_two: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> ##2 in_stall)
        else $error("item finished too soon");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(sample_out))
        else $error("stalled result changed");

endmodule

bind envelope_lfo_swept_wah_filter_top ewah_port_assert u_ewah_port_assert (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out)
);
`default_nettype wire

### verif/ewah_checker.sv
`timescale 1ns / 1ps
// Checker for the envelope/LFO wah: watches the in/out channels and the config port,
// predicts every output item and compares. Depends on ewah_pkg for widths and register codes.
module ewah_checker (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    in_valid,
    input  wire logic                                    in_stall,
    input  wire logic signed [ewah_pkg::SAMPLE_BITS-1:0] sample_in,
    input  wire logic                                    out_valid,
    input  wire logic                                    out_stall,
    input  wire logic signed [ewah_pkg::SAMPLE_BITS-1:0] sample_out,
    input  wire logic                                    cfg_wr_en,
    input  wire logic [2:0]                              cfg_index,
    input  wire logic [31:0]                             cfg_data,
    output int                                           fail_count,
    output int                                           pending
);
    import ewah_pkg::*;

    localparam longint FULL = 64'sd1 << (SAMPLE_BITS - 1);
    localparam longint ONE24 = 64'sd16777216;

    longint unsigned tab_g [CURVE_DEPTH];
    longint unsigned tab_norm [CURVE_DEPTH];
    longint unsigned tab_sine [CURVE_DEPTH];

    logic            mode_auto;
    longint unsigned pedal, sens, step, att, rel;
    longint unsigned env;
    logic [31:0]     phase;
    longint          bp_int, lp_int;

    logic signed [SAMPLE_BITS-1:0] wah_expected [$];

    function automatic longint unsigned sine_taylor(input longint unsigned x);
        longint unsigned x2, term, sum;
        x2 = (x * x) >> 30;
        term = x;
        sum = x;
        for (int n = 1; n <= 7; n++)
        begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) sum = sum - term;
            else sum = sum + term;
        end
        return sum;
    endfunction

    function automatic longint unsigned exp_taylor(input longint unsigned y);
        longint unsigned term, sum;
        term = 64'd1073741824;
        sum = term;
        for (int n = 1; n <= 12; n++)
        begin
            term = ((term * y) >> 30) / longint'(n);
            sum = sum + term;
        end
        return sum;
    endfunction

    task automatic fill_tables();
        longint unsigned d1, n, r, f, hz, w, s, c, g, gg, x, v;
        d1 = CURVE_DEPTH - 1;
        for (int i = 0; i < CURVE_DEPTH; i++)
        begin
            n = (4 * i) / d1;
            r = (4 * i) % d1;
            f = (r << 30) / d1;
            hz = exp_taylor((f * 64'd744261118) >> 30) * (64'd100 << n);
            w = ((hz / 48000) * 64'd3373259426) >> 30;
            if (w > 64'd1686629713) w = 64'd1686629713;
            s = sine_taylor(w);
            c = sine_taylor(64'd1686629713 - w);
            if (c == 0) c = 1;
            g = (s << 24) / c;
            if (g > 64'd16777215) g = 64'd16777215;
            gg = (g * (g + 64'd4660338)) >> 24;
            tab_g[i] = g;
            tab_norm[i] = (64'd1 << 48) / (64'd16777216 + gg);
            n = (4 * i) / CURVE_DEPTH;
            r = (4 * i) % CURVE_DEPTH;
            x = (64'd1686629713 * r) / CURVE_DEPTH;
            s = n[0] ? sine_taylor(64'd1686629713 - x) : sine_taylor(x);
            v = n[1] ? 64'd1073741824 - s : 64'd1073741824 + s;
            tab_sine[i] = v >> 7;
        end
    endtask

    // floor division by 2^24
    function automatic longint floor24(input longint v);
        return v >>> 24;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] wah_step(input longint x);
        longint unsigned a, c, e, e24, pos, idx, si;
        longint g, a1, a2, ga2, v3, v1, v2, y;
        a = x < 0 ? -x : x;
        c = (a > env) ? att : rel;
        env = (c * env + (64'd16777216 - c) * a) >> 24;
        e = env * 3;
        if (e > FULL) e = FULL;
        e24 = (e << 24) >> (SAMPLE_BITS - 1);
        if (mode_auto)
        begin
            phase = phase + step[31:0];
            si = ({32'd0, phase} * CURVE_DEPTH) >> 32;
            pos = 64'd2013266 + ((64'd9227469 * tab_sine[si]) >> 24)
                + ((64'd5872026 * ((sens * e24) >> 16)) >> 24);
        end
        else
        begin
            pos = (((pedal << 8) * 64'd11744051) >> 24)
                + ((64'd6710886 * ((sens * e24) >> 16)) >> 24);
        end
        if (pos > 64'd16777216) pos = 64'd16777216;
        idx = (pos * (CURVE_DEPTH - 1) + 64'd8388608) >> 24;
        g = tab_g[idx];
        a1 = tab_norm[idx];
        a2 = (g * a1) >>> 24;
        ga2 = (g * a2) >>> 24;
        v3 = x - lp_int;
        v1 = floor24(a1 * bp_int + a2 * v3);
        v2 = lp_int + floor24(a2 * bp_int + ga2 * v3);
        bp_int = clip(2 * v1 - bp_int, -64'sd2147483648, 64'sd2147483647);
        lp_int = clip(2 * v2 - lp_int, -64'sd2147483648, 64'sd2147483647);
        y = floor24(64'sd7381975 * v1 + 64'sd2348810 * x);
        return SAMPLE_BITS'(clip(y, -FULL, FULL - 1));
    endfunction

    initial fill_tables();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_auto = 1'b1;
            pedal = 16384;
            sens = 39322;
            step = 683565;
            att = 16719066;
            rel = 16774720;
            env = 0;
            phase = 0;
            bp_int = 0;
            lp_int = 0;
            wah_expected.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_AUTO_MODE:   mode_auto = cfg_data[0];
                    REG_PEDAL:       pedal = cfg_data[15:0];
                    REG_SENSITIVITY: sens = cfg_data[15:0];
                    REG_LFO_STEP:    step = cfg_data;
                    REG_ATTACK:      att = cfg_data[23:0];
                    REG_RELEASE:     rel = cfg_data[23:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                wah_expected.push_back(wah_step(longint'(sample_in)));
            if (out_valid && !out_stall)
            begin
                if (wah_expected.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected output item %0d", sample_out);
                end
                else
                begin
                    logic signed [SAMPLE_BITS-1:0] want;
                    want = wah_expected.pop_front();
                    if (want !== sample_out)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("sample_out mismatch: expected %0d got %0d",
                                     want, sample_out);
                    end
                end
            end
            pending = wah_expected.size();
        end
    end
endmodule

### verif/tb_envelope_lfo_swept_wah_filter_top.sv
`timescale 1ns / 1ps
// Top of the wah testbench: clock, reset, config writes, sample stimulus and verdict.
// Depends on ewah_pkg, envelope_lfo_swept_wah_filter_top and ewah_checker.
module tb_envelope_lfo_swept_wah_filter_top;
    import ewah_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [SAMPLE_BITS-1:0] sample_in = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic cfg_wr_en = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    int fail_count;
    int pending;

    // idle percentages of sender and receiver, changed per phase
    int send_idle = 0;
    int recv_idle = 0;
    logic hold_off = 1'b0;
    int cycles = 0;

    always #1 clk = ~clk;

    envelope_lfo_swept_wah_filter_top u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .sample_in(sample_in),
        .out_valid(out_valid), .out_stall(out_stall), .sample_out(sample_out),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    ewah_checker u_check (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .sample_in(sample_in),
        .out_valid(out_valid), .out_stall(out_stall), .sample_out(sample_out),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    // receiver: random stalls, or a solid hold-off while hold_off is set
    always @(posedge clk)
        out_stall <= hold_off || ($urandom_range(99) < recv_idle);

    // watchdog: the worst case of all items plus long stalls stays far below this limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 2000000)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // one write, then a quiet gap with wr_en low so back-to-back writes never collide
    task automatic write_reg(input ewah_reg_t idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // offer one sample, with an optional random gap first; valid stays high across
    // back-to-back items since it is only lowered when a gap is taken
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample_in <= s;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // drain: stop offering, wait for all results, then let the pipeline settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // random sample: mostly sign-alternating bursts of random level, some full-range noise and full-scale extremes
    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample(input int k,
                                                                  input int amp);
        case ($urandom_range(9))
            0: return SAMPLE_BITS'($urandom);
            1: return $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
            default: return SAMPLE_BITS'(((k % 40) < 20 ? 1 : -1) * int'($urandom_range(amp)));
        endcase
    endfunction

    task automatic run_phase(input int count, input int s_idle, input int r_idle);
        int amp;
        send_idle = s_idle;
        recv_idle = r_idle;
        amp = $urandom_range(8388607);
        for (int k = 0; k < count; k++)
        begin
            if (k % 50 == 0) amp = $urandom_range(8388607);
            send_sample(rand_sample(k, amp));
        end
        drain();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, silence, and an attack/release burst at reset settings
        send_sample(24'sh000000);
        send_sample(24'sh7fffff);
        send_sample(24'sh800000);
        send_sample(24'sh7fffff);
        send_sample(24'sh800000);
        send_sample(24'sh000001);
        send_sample(24'shffffff);
        send_sample(24'sh555555);
        send_sample(24'shaaaaaa);
        send_sample(24'sh000000);
        drain();

        // manual mode: phase holds; max pedal plus full sensitivity clamps the position
        write_reg(REG_AUTO_MODE, 32'd0);
        write_reg(REG_PEDAL, 32'hffff);
        write_reg(REG_SENSITIVITY, 32'hffff);
        write_reg(REG_ATTACK, 32'd0);
        write_reg(REG_RELEASE, 32'hffffff);
        for (int k = 0; k < 8; k++)
            send_sample(k[0] ? 24'sh7fffff : 24'sh800000);
        drain();
        write_reg(REG_PEDAL, 32'd0);
        write_reg(REG_SENSITIVITY, 32'd0);
        write_reg(REG_ATTACK, 32'hffffff);
        write_reg(REG_RELEASE, 32'd0);
        write_reg(REG_LFO_STEP, 32'hffffffff);
        send_sample(24'sh400000);
        send_sample(24'shc00000);
        send_sample(24'sh7fffff);
        drain();

        // random phases over several settings and idling mixes
        write_reg(REG_AUTO_MODE, 32'hffff_fffe | 32'd1);
        write_reg(REG_LFO_STEP, 32'd683565);
        write_reg(REG_ATTACK, 32'd16719066);
        write_reg(REG_RELEASE, 32'd16774720);
        write_reg(REG_SENSITIVITY, 32'd39322);
        run_phase(200, 0, 0);

        write_reg(REG_LFO_STEP, $urandom);
        write_reg(REG_SENSITIVITY, $urandom);
        run_phase(200, 57, 0);

        write_reg(REG_AUTO_MODE, 32'd0);
        write_reg(REG_PEDAL, $urandom);
        write_reg(REG_ATTACK, $urandom);
        write_reg(REG_RELEASE, $urandom);
        run_phase(200, 0, 57);

        write_reg(REG_AUTO_MODE, 32'd1);
        write_reg(REG_LFO_STEP, 32'h4000_0000);
        write_reg(REG_SENSITIVITY, 32'hffff);
        run_phase(200, 32, 32);

        // long receiver hold-off while the sender keeps offering items
        send_idle = 0;
        recv_idle = 0;
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int k = 0; k < 40; k++)
                send_sample(rand_sample(k, 8388607));
        join
        drain();

        write_reg(REG_LFO_STEP, $urandom);
        write_reg(REG_ATTACK, $urandom_range(16777215, 16000000));
        write_reg(REG_RELEASE, $urandom_range(16777215, 16000000));
        write_reg(REG_SENSITIVITY, $urandom);
        run_phase(220, 32, 32);
        run_phase(200, 0, 0);

        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
